/* rtl/core/tdpt_pkg.sv */
// Shared types and constants for the trial-division prime tester.
// Used by every module under rtl/core; depends on nothing.
package tdpt_pkg;

	localparam int VALUE_WIDTH = 20;
	// Running divisor square; wide enough for any divisor the walk reaches.
	localparam int SQ_W = 2 * VALUE_WIDTH + 2;
	localparam int CNT_W = $clog2(VALUE_WIDTH);
	localparam int Q_DEPTH = 2;
	localparam int Q_AW = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = Q_AW + 1;

	localparam logic [VALUE_WIDTH-1:0] VAL_TWO = VALUE_WIDTH'(2);
	localparam logic [VALUE_WIDTH-1:0] VAL_FOUR = VALUE_WIDTH'(4);
	localparam logic [VALUE_WIDTH-1:0] FIRST_DIV = VALUE_WIDTH'(3);
	localparam logic [SQ_W-1:0] FIRST_SQ = SQ_W'(9);

	typedef enum logic [1:0] {
		CLS_NOT_PRIME,
		CLS_PRIME,
		CLS_TEST
	} cls_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_CHECK,
		BK_DIV,
		BK_FIN
	} back_state_t;

	typedef struct packed {
		logic [VALUE_WIDTH-1:0] value;
		logic                   last;
		cls_t                   cls;
	} qent_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

/* rtl/core/tdpt_front.sv */
// Front end: takes requests and sorts out trivial candidates in one stage.
// Depends on tdpt_pkg; feeds tdpt_queue.
module tdpt_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [tdpt_pkg::VALUE_WIDTH-1:0] candidate,
	input  logic                            range_end,
	input  tdpt_pkg::q_stat_t               q_stat,
	output logic                            q_push,
	output tdpt_pkg::qent_t                 q_wdata
);

	logic            v_s1;
	tdpt_pkg::qent_t ent_s1;
	tdpt_pkg::cls_t  cls;
	logic            adv;
	logic            accept;

	// Zero and one are not prime, two and three are, other evens fall to divisor two.
	always_comb begin
		if (candidate < tdpt_pkg::VAL_TWO) begin
			cls = tdpt_pkg::CLS_NOT_PRIME;
		end else if (candidate < tdpt_pkg::VAL_FOUR) begin
			cls = tdpt_pkg::CLS_PRIME;
		end else if (!candidate[0]) begin
			cls = tdpt_pkg::CLS_NOT_PRIME;
		end else begin
			cls = tdpt_pkg::CLS_TEST;
		end
	end

	assign adv    = !v_s1 || !q_stat.full;
	assign full   = !adv;
	assign accept = push && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ent_s1.value <= candidate;
			ent_s1.last  <= range_end;
			ent_s1.cls   <= cls;
		end
	end

	assign q_push  = v_s1;
	assign q_wdata = ent_s1;

endmodule

/* rtl/core/tdpt_queue.sv */
// Short request queue between the front end and the divider back end.
// Depends on tdpt_pkg.
module tdpt_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  tdpt_pkg::qent_t     wdata,
	input  logic                pop,
	output tdpt_pkg::qent_t     rdata,
	output tdpt_pkg::q_stat_t   stat
);

	tdpt_pkg::qent_t                 mem [tdpt_pkg::Q_DEPTH];
	logic [tdpt_pkg::Q_AW-1:0]      wr_ptr_q;
	logic [tdpt_pkg::Q_AW-1:0]      rd_ptr_q;
	logic [tdpt_pkg::Q_CNT_W-1:0]   count_q;
	logic                            do_push;
	logic                            do_pop;

	assign stat.full  = (count_q == tdpt_pkg::Q_CNT_W'(tdpt_pkg::Q_DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rdata      = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

endmodule

/* rtl/core/tdpt_back.sv */
// Back end: walks odd divisors with a bit-serial remainder unit and holds
// the result register. Depends on tdpt_pkg; reads from tdpt_queue.
module tdpt_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tdpt_pkg::q_stat_t                q_stat,
	input  tdpt_pkg::qent_t                  q_rdata,
	output logic                             q_pop,
	output logic                             out_valid,
	input  logic                             out_pop,
	output logic [tdpt_pkg::VALUE_WIDTH-1:0] out_value,
	output logic                             out_prime,
	output logic                             out_last
);

	localparam int W = tdpt_pkg::VALUE_WIDTH;

	tdpt_pkg::back_state_t         state_q;
	tdpt_pkg::back_state_t         state_d;
	logic [W-1:0]                  n_q;
	logic                          last_q;
	logic                          prime_q;
	logic [W-1:0]                  d_q;
	logic [tdpt_pkg::SQ_W-1:0]     sq_q;
	logic [W-1:0]                  rem_q;
	logic [tdpt_pkg::CNT_W-1:0]    cnt_q;
	logic                          out_valid_q;

	logic [W:0]                    trial;
	logic [W-1:0]                  rem_nxt;
	logic                          sq_gt;
	logic                          slot_free;
	logic                          load_out;

	// One restoring step: shift in the next candidate bit, subtract if it fits.
	always_comb begin
		trial = {rem_q, n_q[cnt_q]};
		if (trial >= {1'b0, d_q}) begin
			rem_nxt = W'(trial - {1'b0, d_q});
		end else begin
			rem_nxt = trial[W-1:0];
		end
	end

	assign sq_gt     = (sq_q > tdpt_pkg::SQ_W'(n_q));
	assign slot_free = !out_valid_q || out_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tdpt_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			tdpt_pkg::BK_IDLE: begin
				if (!q_stat.empty) begin
					q_pop = 1'b1;
					if (q_rdata.cls == tdpt_pkg::CLS_TEST) begin
						state_d = tdpt_pkg::BK_CHECK;
					end else begin
						state_d = tdpt_pkg::BK_FIN;
					end
				end
			end
			tdpt_pkg::BK_CHECK: begin
				if (sq_gt) begin
					state_d = tdpt_pkg::BK_FIN;
				end else begin
					state_d = tdpt_pkg::BK_DIV;
				end
			end
			tdpt_pkg::BK_DIV: begin
				if (cnt_q == '0) begin
					if (rem_nxt == '0) begin
						state_d = tdpt_pkg::BK_FIN;
					end else begin
						state_d = tdpt_pkg::BK_CHECK;
					end
				end
			end
			tdpt_pkg::BK_FIN: begin
				if (slot_free) begin
					load_out = 1'b1;
					state_d  = tdpt_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = tdpt_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			tdpt_pkg::BK_IDLE: begin
				if (q_pop) begin
					n_q     <= q_rdata.value;
					last_q  <= q_rdata.last;
					prime_q <= (q_rdata.cls == tdpt_pkg::CLS_PRIME);
					d_q     <= tdpt_pkg::FIRST_DIV;
					sq_q    <= tdpt_pkg::FIRST_SQ;
				end
			end
			tdpt_pkg::BK_CHECK: begin
				rem_q <= '0;
				cnt_q <= tdpt_pkg::CNT_W'(W - 1);
				if (sq_gt) begin
					prime_q <= 1'b1;
				end
			end
			tdpt_pkg::BK_DIV: begin
				rem_q <= rem_nxt;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					if (rem_nxt == '0) begin
						prime_q <= 1'b0;
					end else begin
						// advance to the next odd divisor: (d+2)^2 = d^2 + 4d + 4
						d_q  <= d_q + tdpt_pkg::VAL_TWO;
						sq_q <= sq_q + (tdpt_pkg::SQ_W'(d_q) << 2) + tdpt_pkg::SQ_W'(4);
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_value <= n_q;
			out_prime <= prime_q;
			out_last  <= last_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* rtl/core/trial_division_prime_test.sv */
// Top level of the trial-division prime tester: front end, request queue, back end.
// Depends on tdpt_pkg, tdpt_front, tdpt_queue and tdpt_back.
//
//   channel   handshake     payload                         accepted when
//   input     push / full   candidate[19:0], range_end      push && !full
//   result    empty / pop   tested_value[19:0], is_prime,   pop && !empty
//                           last
//
// Candidates 0..3 and even ones are settled in the front end and skip the divisor walk.
// An odd candidate n >= 5 runs odd divisors d = 3, 5, ... while d*d <= n; each
// divisor takes a compare state and then the bit-serial remainder unit, and the
// walk stops early at the first divisor that divides n.
// The front stage and a two-entry queue keep taking requests while the back end works.
// Reset is asynchronous and empties every stage; results stay put while pop is low.
module trial_division_prime_test (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic [tdpt_pkg::VALUE_WIDTH-1:0] candidate,
	input  logic                             range_end,
	output logic                             empty,
	input  logic                             pop,
	output logic [tdpt_pkg::VALUE_WIDTH-1:0] tested_value,
	output logic                             is_prime,
	output logic                             last
);

	tdpt_pkg::q_stat_t q_stat;
	tdpt_pkg::qent_t   q_wdata;
	tdpt_pkg::qent_t   q_rdata;
	logic              q_push;
	logic              q_pop;
	logic              out_valid;

	tdpt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.candidate (candidate),
		.range_end (range_end),
		.q_stat    (q_stat),
		.q_push    (q_push),
		.q_wdata   (q_wdata)
	);

	tdpt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.stat   (q_stat)
	);

	tdpt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.q_rdata   (q_rdata),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_pop   (pop),
		.out_value (tested_value),
		.out_prime (is_prime),
		.out_last  (last)
	);

	assign empty = !out_valid;

	a_prime_ge_two: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && is_prime) |-> (tested_value >= tdpt_pkg::VAL_TWO))
		else $error("prime flag on a value below two");

	a_even_prime_is_two: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && is_prime && !tested_value[0]) |-> (tested_value == tdpt_pkg::VAL_TWO))
		else $error("even value other than two flagged prime");

	a_queue_stat: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("request queue both full and empty");

	a_front_stall: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> (q_push && q_stat.full))
		else $error("front end stalled without a full queue");

endmodule

/* tb/sv/trial_division_prime_test_tb.sv */
// Testbench for trial_division_prime_test: candidates go in through push/full, and each
// verdict is popped through empty/pop and checked against a trial-division predictor.
// Depends on tdpt_pkg and the trial_division_prime_test RTL.
`timescale 1ns / 1ps

module trial_division_prime_test_tb;

	localparam int VW = tdpt_pkg::VALUE_WIDTH;
	localparam int IDLE_LIMIT = 60000;
	localparam int LONG_HOLD = 600;
	localparam logic [VW-1:0] VALUE_MAX = {VW{1'b1}};

	typedef struct {
		logic [VW-1:0] value;
		logic          prime;
		logic          mark;
	} verdict_t;

	typedef enum int {
		POP_ALWAYS,
		POP_HALF,
		POP_QUARTER,
		POP_NONE
	} pop_mode_t;

	logic          clk = 1'b0;
	logic          arst_n;
	logic          push;
	logic          full;
	logic [VW-1:0] candidate;
	logic          range_end;
	logic          empty;
	logic          pop;
	logic [VW-1:0] tested_value;
	logic          is_prime;
	logic          last;

	verdict_t pending_verdicts[$];
	int       error_count = 0;
	int       burst_left = 0;
	int       idle_cycles = 0;
	bit       steady_send = 1'b0;
	bit       hold_req = 1'b0;

	trial_division_prime_test i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.candidate   (candidate),
		.range_end   (range_end),
		.empty       (empty),
		.pop         (pop),
		.tested_value(tested_value),
		.is_prime    (is_prime),
		.last        (last)
	);

	always #2 clk = ~clk;

	function automatic logic prime_by_division(logic [VW-1:0] n);
		longint unsigned num;
		longint unsigned d;
		num = n;
		if (num < 2)
			return 1'b0;
		for (d = 2; d * d <= num; d++) begin
			if (num % d == 0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// Mostly small values so the run stays short; now and then the full width.
	function automatic logic [VW-1:0] random_candidate();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			return VW'($urandom_range(0, 1023));
		else if (pick < 75)
			return VW'($urandom_range(0, 65535));
		else if (pick < 87)
			return VW'($urandom) & ~VW'(1);
		else
			return VW'($urandom);
	endfunction

	task automatic send_request(input logic [VW-1:0] value, input logic mark);
		verdict_t want;
		int gap;
		if (!steady_send && burst_left == 0) begin
			// Skip the gap now and then so some bursts run back to back.
			if ($urandom_range(0, 3) != 0) begin
				gap = $urandom_range(1, 12);
				@(negedge clk);
				push <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		@(negedge clk);
		push <= 1'b1;
		candidate <= value;
		range_end <= mark;
		@(posedge clk);
		while (full) @(posedge clk);
		want.value = value;
		want.prime = prime_by_division(value);
		want.mark = mark;
		pending_verdicts.insert(pending_verdicts.size(), want);
		if (burst_left > 0)
			burst_left--;
	endtask

	task automatic pause_sender();
		@(negedge clk);
		push <= 1'b0;
	endtask

	task automatic wait_drained();
		pause_sender();
		while (pending_verdicts.size() != 0) @(posedge clk);
	endtask

	task automatic test_small_values();
		send_request(VW'(0), 1'b0);
		send_request(VW'(1), 1'b1);
		send_request(VW'(2), 1'b0);
		send_request(VW'(3), 1'b1);
		send_request(VW'(4), 1'b0);
		send_request(VW'(5), 1'b0);
		send_request(VW'(9), 1'b1);
		send_request(VW'(25), 1'b0);
	endtask

	task automatic test_extremes();
		send_request(VALUE_MAX, 1'b1);
		send_request(VALUE_MAX - VW'(1), 1'b0);
		// Largest prime below 2**20, then a prime square that ends the walk exactly.
		send_request(VW'(1048573), 1'b1);
		send_request(VW'(1042441), 1'b0);
		send_request(VW'(999983), 1'b1);
		send_request(VW'(524288), 1'b0);
		send_request(VW'(961), 1'b1);
		send_request(VW'(7), 1'b0);
		send_request(VW'(49), 1'b1);
	endtask

	task automatic test_fill_under_stall();
		steady_send = 1'b1;
		hold_req = 1'b1;
		// Even values settle fast, so the stages fill while pop is held low.
		repeat (16) send_request(VW'($urandom) & ~VW'(1), 1'($urandom_range(0, 1)));
		steady_send = 1'b0;
	endtask

	task automatic test_pause_until_drained();
		repeat (6) send_request(random_candidate(), 1'($urandom_range(0, 1)));
		wait_drained();
		repeat (6) send_request(random_candidate(), 1'($urandom_range(0, 1)));
	endtask

	task automatic test_random_ranges(input int count);
		int sent;
		int span;
		logic [VW-1:0] start;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 2) == 0) begin
				send_request(random_candidate(), ($urandom_range(0, 7) == 0));
				sent++;
			end else begin
				// Walk odd candidates of a range and mark the last one.
				span = $urandom_range(3, 10);
				if ($urandom_range(0, 7) == 0)
					start = VW'($urandom_range(0, 32'hFFF00)) | VW'(1);
				else
					start = VW'($urandom_range(0, 4095)) | VW'(1);
				for (int k = 0; k < span; k++) begin
					send_request(start + VW'(2 * k), (k == span - 1));
					sent++;
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		candidate = '0;
		range_end = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_small_values();
		test_extremes();
		test_fill_under_stall();
		test_pause_until_drained();
		test_random_ranges(240);
		wait_drained();
		repeat (40) @(posedge clk);
		if (error_count == 0)
			$display("trial_division_prime_test_tb: done, clean");
		else
			$display("trial_division_prime_test_tb: done, errors");
		$finish;
	end

	always @(negedge clk) begin : receiver_pattern
		int        hold_left = 0;
		int        mode_left = 0;
		pop_mode_t mode = POP_ALWAYS;
		logic      next_pop;
		if (hold_req) begin
			hold_left = LONG_HOLD;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			next_pop = 1'b0;
		end else begin
			if (mode_left == 0) begin
				mode = pop_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(8, 80);
			end
			mode_left--;
			case (mode)
				POP_ALWAYS: next_pop = 1'b1;
				POP_HALF: next_pop = 1'($urandom_range(0, 1));
				POP_QUARTER: next_pop = ($urandom_range(0, 3) == 0);
				default: next_pop = 1'b0;
			endcase
		end
		pop <= next_pop;
	end

	always @(posedge clk) begin : check_results
		verdict_t want;
		if (arst_n && pop && !empty) begin
			if (pending_verdicts.size() == 0) begin
				$error("result with no request pending: tested_value=%0d", tested_value);
				error_count++;
			end else begin
				want = pending_verdicts.pop_front();
				if (tested_value !== want.value) begin
					$error("tested_value: expected %0d, got %0d", want.value, tested_value);
					error_count++;
				end
				if (is_prime !== want.prime) begin
					$error("is_prime: expected %0b, got %0b (value %0d)",
						want.prime, is_prime, want.value);
					error_count++;
				end
				if (last !== want.mark) begin
					$error("last: expected %0b, got %0b (value %0d)",
						want.mark, last, want.value);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("trial_division_prime_test_tb: done, errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
